/* rtl/utf8_dec_pkg.sv */
// ----------------------------------------------------------------------------
// utf8_dec_pkg
// shared types and constants of the six-byte utf-8 byte stream decoder
// ----------------------------------------------------------------------------
package utf8_dec_pkg;

    // byte transaction from the stream source
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } byte_item_t;

    // decoded code point transaction
    typedef struct packed {
        logic [31:0] code_point;
        logic [1:0]  status;
    } cp_item_t;

    // decoder state carried between bytes
    typedef struct packed {
        logic [31:0] accumulator;
        logic [2:0]  bytes_remaining;
    } dec_state_t;

    // status codes
    localparam logic [1:0] STATUS_OK  = 2'd0;
    localparam logic [1:0] STATUS_BAD = 2'd1;
    localparam logic [1:0] STATUS_EOF = 2'd2;

    // lead byte upper bounds per sequence length
    localparam logic [7:0] LEAD_ONE_MAX   = 8'd127;
    localparam logic [7:0] LEAD_TWO_MAX   = 8'd223;
    localparam logic [7:0] LEAD_THREE_MAX = 8'd239;
    localparam logic [7:0] LEAD_FOUR_MAX  = 8'd247;
    localparam logic [7:0] LEAD_FIVE_MAX  = 8'd251;
    localparam logic [7:0] LEAD_SIX_MAX   = 8'd253;

    // payload offsets removed from lead and continuation bytes
    localparam logic [31:0] BASE_TWO   = 32'd192;
    localparam logic [31:0] BASE_THREE = 32'd224;
    localparam logic [31:0] BASE_FOUR  = 32'd240;
    localparam logic [31:0] BASE_FIVE  = 32'd248;
    localparam logic [31:0] BASE_SIX   = 32'd252;
    localparam logic [31:0] CONT_BASE  = 32'd128;

endpackage

/* rtl/utf8_dec_step.sv */
// ----------------------------------------------------------------------------
// utf8_dec_step
// per-byte decode step: next state and optional result from one byte
// ----------------------------------------------------------------------------
module utf8_dec_step
    import utf8_dec_pkg::*;
(
    input  byte_item_t item,
    input  dec_state_t state_cur,
    output dec_state_t state_nxt,
    output logic       emit,
    output cp_item_t   result
);

    logic [31:0] byte_ext;
    logic [31:0] acc_shift;
    logic [2:0]  rem_dec;

    assign byte_ext  = {24'd0, item.data_byte};
    assign acc_shift = {state_cur.accumulator[25:0], 6'd0} + (byte_ext - CONT_BASE);
    assign rem_dec   = state_cur.bytes_remaining - 3'd1;

    always_comb
    begin
        state_nxt         = state_cur;
        emit              = 1'b0;
        result.code_point = 32'd0;
        result.status     = STATUS_OK;
        if (item.end_of_stream)
        begin
            // partial sequence dropped
            state_nxt     = '0;
            emit          = 1'b1;
            result.status = STATUS_EOF;
        end
        else if (state_cur.bytes_remaining != 3'd0)
        begin
            // continuation bytes are not checked
            state_nxt.bytes_remaining = rem_dec;
            if (rem_dec == 3'd0)
            begin
                state_nxt.accumulator = 32'd0;
                emit                  = 1'b1;
                result.code_point     = acc_shift;
            end
            else
            begin
                state_nxt.accumulator = acc_shift;
            end
        end
        else if (item.data_byte <= LEAD_ONE_MAX)
        begin
            emit              = 1'b1;
            result.code_point = byte_ext;
        end
        else if (item.data_byte <= LEAD_TWO_MAX)
        begin
            // stray continuation bytes land here too, wrapping below zero
            state_nxt.accumulator     = byte_ext - BASE_TWO;
            state_nxt.bytes_remaining = 3'd1;
        end
        else if (item.data_byte <= LEAD_THREE_MAX)
        begin
            state_nxt.accumulator     = byte_ext - BASE_THREE;
            state_nxt.bytes_remaining = 3'd2;
        end
        else if (item.data_byte <= LEAD_FOUR_MAX)
        begin
            state_nxt.accumulator     = byte_ext - BASE_FOUR;
            state_nxt.bytes_remaining = 3'd3;
        end
        else if (item.data_byte <= LEAD_FIVE_MAX)
        begin
            state_nxt.accumulator     = byte_ext - BASE_FIVE;
            state_nxt.bytes_remaining = 3'd4;
        end
        else if (item.data_byte <= LEAD_SIX_MAX)
        begin
            state_nxt.accumulator     = byte_ext - BASE_SIX;
            state_nxt.bytes_remaining = 3'd5;
        end
        else
        begin
            state_nxt     = '0;
            emit          = 1'b1;
            result.status = STATUS_BAD;
        end
    end

endmodule

/* rtl/utf8_byte_stream_decoder.sv */
// ----------------------------------------------------------------------------
// utf8_byte_stream_decoder
// byte-serial decoder for the original six-byte utf-8 form
// ----------------------------------------------------------------------------
// usage
//  - byte channel: byte_valid / byte_stall / byte_item carry one raw byte or
//    an end-of-stream marker per transaction
//  - code point channel: cp_valid / cp_stall / cp_item carry one decoded
//    code point with a status (ok, bad lead byte, end of stream)
//  - a transaction completes on a rising edge with valid high and stall low
//  - a completing byte waits in the input register, then its result is
//    held in the result register
//  - throughput: one byte per cycle while byte_stall is low; the only loop is
//    the accumulator update, a 6-bit shift and one 32-bit add
//  - bytes that only extend a sequence produce no result transaction
//  - while cp_stall holds a result, bytes that complete no code point still
//    pass through; the next completing byte waits in the input register
//    and byte_stall rises until the result slot frees
//  - reset clears the decoder state and both valid flags at once
// ----------------------------------------------------------------------------
module utf8_byte_stream_decoder
    import utf8_dec_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_stall,
    input  byte_item_t byte_item,
    output logic       cp_valid,
    input  logic       cp_stall,
    output cp_item_t   cp_item
);

    // input register
    logic       in_vld_reg;
    byte_item_t in_item_reg;

    // decoder state
    dec_state_t state_reg;
    dec_state_t state_next;

    // result register
    logic       out_vld_reg;
    cp_item_t   out_item_reg;

    logic       step_emit;
    cp_item_t   step_result;
    logic       out_free;
    logic       advance;

    utf8_dec_step u_step (
        .item      (in_item_reg),
        .state_cur (state_reg),
        .state_nxt (state_next),
        .emit      (step_emit),
        .result    (step_result)
    );

    // result slot can take a new transaction this cycle
    assign out_free = !out_vld_reg || !cp_stall;

    // held byte moves through the decode step; bytes with no result never wait
    assign advance = in_vld_reg && (out_free || !step_emit);

    // input register is blocked only when its byte cannot advance
    assign byte_stall = in_vld_reg && !advance;

    assign cp_valid = out_vld_reg;
    assign cp_item  = out_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= '0;
        end
        else
        begin
            // input stage
            if (byte_valid && !byte_stall)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            // decoder state follows each decoded byte
            if (advance)
            begin
                state_reg <= state_next;
            end

            // result stage
            if (advance && step_emit)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (!cp_stall)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (byte_valid && !byte_stall)
        begin
            in_item_reg <= byte_item;
        end
        if (advance && step_emit)
        begin
            out_item_reg <= step_result;
        end
    end

endmodule
